### sv/ecd_pkg.sv
package ecd_pkg;

  localparam int FLOOR_W     = 7;
  localparam int ROOM_W      = 8;
  localparam int COST_W      = 10;
  localparam int OUT_COST_W  = 7;
  localparam int CAR_FIELD_W = 3;
  localparam int CARS_W      = 4;
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [1:0] {
    OP_STATUS  = 2'd0,
    OP_REQUEST = 2'd1,
    OP_BOARD   = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THIS_FLOOR  = 2'd0,
    REG_TOP_FLOOR   = 2'd1,
    REG_CARS_IN_USE = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic [FLOOR_W-1:0] floor;
    logic               active;
    logic               up;
    logic               open;
    logic [ROOM_W-1:0]  room;
  } car_entry_t;

  typedef struct packed {
    logic upd;
    logic board;
    logic incr;
    logic dir_up;
  } tbl_cmd_t;

  typedef struct packed {
    logic en;
    logic first;
  } scan_ctl_t;

endpackage

### sv/ecd_car_table.sv
module ecd_car_table #(
  parameter int MAX_CARS    = 8,
  parameter int MAX_WAITING = 255,
  localparam int CW = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1,
  localparam int WW = $clog2(MAX_WAITING + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ecd_pkg::tbl_cmd_t   cmd,
  input  logic [CW-1:0]       wr_idx,
  input  ecd_pkg::car_entry_t wr_entry,
  input  logic [CW-1:0]       rd_idx,
  input  logic                rd_up,
  output ecd_pkg::car_entry_t rd_entry,
  output logic [WW-1:0]       rd_wait
);

  logic [ecd_pkg::FLOOR_W-1:0] pos_r  [MAX_CARS];
  logic                        act_r  [MAX_CARS];
  logic                        up_r   [MAX_CARS];
  logic                        open_r [MAX_CARS];
  logic [ecd_pkg::ROOM_W-1:0]  room_r [MAX_CARS];
  logic [WW-1:0]               wup_r  [MAX_CARS];
  logic [WW-1:0]               wdn_r  [MAX_CARS];

  // Car positions are not cleared; the user must report a car before it is used, which this table does not enforce.
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      pos_r[wr_idx] <= wr_entry.floor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CARS; i++) begin
        act_r[i]  <= 1'b0;
        up_r[i]   <= 1'b0;
        open_r[i] <= 1'b0;
        room_r[i] <= '0;
        wup_r[i]  <= '0;
        wdn_r[i]  <= '0;
      end
    end else begin
      if (cmd.upd) begin
        act_r[wr_idx]  <= wr_entry.active;
        up_r[wr_idx]   <= wr_entry.up;
        open_r[wr_idx] <= wr_entry.open;
        room_r[wr_idx] <= wr_entry.room;
      end
      if (cmd.board) begin
        if (cmd.dir_up) begin
          if (wup_r[wr_idx] != '0) begin
            wup_r[wr_idx] <= wup_r[wr_idx] - WW'(1);
          end
        end else begin
          if (wdn_r[wr_idx] != '0) begin
            wdn_r[wr_idx] <= wdn_r[wr_idx] - WW'(1);
          end
        end
      end
      if (cmd.incr) begin
        if (cmd.dir_up) begin
          if (wup_r[wr_idx] != WW'(MAX_WAITING)) begin
            wup_r[wr_idx] <= wup_r[wr_idx] + WW'(1);
          end
        end else begin
          if (wdn_r[wr_idx] != WW'(MAX_WAITING)) begin
            wdn_r[wr_idx] <= wdn_r[wr_idx] + WW'(1);
          end
        end
      end
    end
  end

  always_comb begin
    rd_entry.floor  = pos_r[rd_idx];
    rd_entry.active = act_r[rd_idx];
    rd_entry.up     = up_r[rd_idx];
    rd_entry.open   = open_r[rd_idx];
    rd_entry.room   = room_r[rd_idx];
    rd_wait         = rd_up ? wup_r[rd_idx] : wdn_r[rd_idx];
  end

endmodule

### sv/ecd_cost_unit.sv
module ecd_cost_unit #(
  parameter int MAX_CARS    = 8,
  parameter int MAX_WAITING = 255,
  localparam int CW = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1,
  localparam int WW = $clog2(MAX_WAITING + 1),
  localparam int SW = ((WW > ecd_pkg::ROOM_W) ? WW : ecd_pkg::ROOM_W) + 1
) (
  input  logic                               clk,
  input  ecd_pkg::scan_ctl_t                 ctl,
  input  logic [CW-1:0]                      k,
  input  ecd_pkg::car_entry_t                entry,
  input  logic [WW-1:0]                      wait_cnt,
  input  logic [ecd_pkg::FLOOR_W-1:0]        here,
  input  logic [ecd_pkg::FLOOR_W-1:0]        top,
  input  logic                               req_up,
  output logic [CW-1:0]                      best_idx,
  output logic signed [ecd_pkg::COST_W-1:0]  best_cost
);

  localparam int CSW = ecd_pkg::COST_W;

  logic [CW-1:0]         best_idx_r;
  logic signed [CSW-1:0] best_cost_r;
  logic signed [SW-1:0]  best_space_r;

  logic signed [CSW-1:0] here_s, pos_s, top_s, cost;
  logic signed [SW-1:0]  space;
  logic [ecd_pkg::FLOOR_W-1:0] span;
  logic approach_up, same_dir, at_here, passing, take;

  always_comb begin
    here_s      = $signed(CSW'(here));
    pos_s       = $signed(CSW'(entry.floor));
    top_s       = $signed(CSW'(top));
    approach_up = here > entry.floor;
    same_dir    = entry.up == req_up;
    at_here     = (entry.floor == here) && same_dir && entry.open;
    passing     = same_dir && (approach_up == entry.up);
    span        = (entry.floor > here) ? (entry.floor - here) : (here - entry.floor);
    if (!entry.active || at_here || passing) begin
      cost = $signed(CSW'(span));
    end else if (entry.up) begin
      cost = top_s + top_s - here_s - pos_s;
    end else begin
      cost = here_s + pos_s - $signed(CSW'(2));
    end
    space = $signed(SW'(entry.room)) - $signed(SW'(wait_cnt));
    take  = ctl.first || (cost < best_cost_r) ||
            ((cost == best_cost_r) && (space > best_space_r));
  end

  always_ff @(posedge clk) begin
    if (ctl.en && take) begin
      best_idx_r   <= k;
      best_cost_r  <= cost;
      best_space_r <= space;
    end
  end

  assign best_idx  = best_idx_r;
  assign best_cost = best_cost_r;

endmodule

### sv/elevator_car_dispatch.sv
// Car dispatcher for one floor.
// The input stream carries one command per transfer, its opcode in in_tuser:
// a car status update or a boarding is absorbed in the cycle of its transfer
// and gives no result; a passenger request gives exactly one result transfer
// on the output stream (chosen car, queue direction and travel cost).
// A request scans the car table one entry per cycle through a single cost and
// compare unit, then commits the waiting count of the chosen car. A request
// holds the input until it is committed, and its result is loaded into the
// output register at the commit. While no request is in flight, updates and
// boardings sustain one transfer per cycle.
// The output register keeps a finished result until it is taken; while it is
// held, the block still takes updates, boardings and the scan of a further
// request, but stops before committing that request.
// The configuration port writes this floor, the top floor and the number of
// cars in use; write it only while no request is in flight.
// Reset restores the register defaults, clears all car flags, free space and
// waiting counts, and empties the output register. Car floors are not
// cleared and must be reported before a car takes part in selection.
module elevator_car_dispatch #(
  parameter int MAX_CARS    = 8,
  parameter int MAX_WAITING = 255
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [ecd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ecd_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // car_index, car_floor, car_busy, car_going_up, car_door_open,
  // car_free_space, boarded_up, destination_floor, zero fill
  input  logic [ecd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // opcode
  input  logic [ecd_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // chosen_car, queue_up, chosen_cost, zero fill
  output logic [ecd_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int CW  = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
  localparam int WW  = $clog2(MAX_WAITING + 1);
  localparam int IXW = (CW > ecd_pkg::CAR_FIELD_W) ? CW : ecd_pkg::CAR_FIELD_W;
  localparam int FW  = ecd_pkg::FLOOR_W;

  ecd_pkg::state_t state_r, state_nxt;

  logic [FW-1:0]             this_floor_r;
  logic [FW-1:0]             top_floor_r;
  logic [ecd_pkg::CARS_W-1:0] cars_r;
  logic [CW-1:0]             k_r, k_nxt;
  logic [CW-1:0]             last_r, last_nxt;
  logic                      req_up_r, req_up_nxt;
  logic                      out_tvalid_r;
  logic [ecd_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  ecd_pkg::opcode_t    op;
  ecd_pkg::tbl_cmd_t   cmd;
  ecd_pkg::scan_ctl_t  ctl;
  ecd_pkg::car_entry_t wr_entry, rd_entry;
  logic [IXW-1:0]      in_idx_ext, best_ext;
  logic [CW-1:0]       wr_idx, best_idx;
  logic [WW-1:0]       rd_wait;
  logic signed [ecd_pkg::COST_W-1:0] best_cost;
  logic [ecd_pkg::OUT_COST_W-1:0]    cost_sat;
  logic [FW-1:0]       dest;
  logic                in_acc, idx_ok, commit_go, scan_last;

  assign op         = ecd_pkg::opcode_t'(in_tuser);
  assign in_acc     = in_tvalid && in_tready;
  assign in_idx_ext = IXW'(in_tdata[2:0]);
  assign idx_ok     = 32'(in_tdata[2:0]) < MAX_CARS;
  assign dest       = in_tdata[28:22];
  assign scan_last  = k_r == last_r;
  assign commit_go  = (state_r == ecd_pkg::S_COMMIT) && (!out_tvalid_r || out_tready);
  assign best_ext   = IXW'(best_idx);

  always_comb begin
    wr_entry.floor  = in_tdata[9:3];
    wr_entry.active = in_tdata[10];
    wr_entry.up     = in_tdata[11];
    wr_entry.open   = in_tdata[12];
    wr_entry.room   = in_tdata[20:13];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      this_floor_r <= FW'(1);
      top_floor_r  <= FW'(16);
      cars_r       <= ecd_pkg::CARS_W'(8);
    end else if (cfg_wr_en) begin
      priority if (cfg_index == ecd_pkg::REG_THIS_FLOOR) begin
        this_floor_r <= cfg_wr_data;
      end else if (cfg_index == ecd_pkg::REG_TOP_FLOOR) begin
        top_floor_r <= cfg_wr_data;
      end else if (cfg_index == ecd_pkg::REG_CARS_IN_USE) begin
        cars_r <= cfg_wr_data[ecd_pkg::CARS_W-1:0];
      end else begin
        this_floor_r <= this_floor_r;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ecd_pkg::S_IDLE: begin
        if (in_acc && op == ecd_pkg::OP_REQUEST) begin
          state_nxt = ecd_pkg::S_SCAN;
        end
      end
      ecd_pkg::S_SCAN: begin
        if (scan_last) begin
          state_nxt = ecd_pkg::S_COMMIT;
        end
      end
      ecd_pkg::S_COMMIT: begin
        if (commit_go) begin
          state_nxt = ecd_pkg::S_IDLE;
        end
      end
      default: state_nxt = ecd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    ctl.en     = 1'b0;
    ctl.first  = k_r == '0;
    cmd.upd    = 1'b0;
    cmd.board  = 1'b0;
    cmd.incr   = 1'b0;
    cmd.dir_up = in_tdata[21];
    wr_idx     = in_idx_ext[CW-1:0];
    unique case (state_r)
      ecd_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.upd   = in_acc && op == ecd_pkg::OP_STATUS && idx_ok;
        cmd.board = in_acc && op == ecd_pkg::OP_BOARD && idx_ok;
      end
      ecd_pkg::S_SCAN: begin
        ctl.en = 1'b1;
      end
      ecd_pkg::S_COMMIT: begin
        cmd.incr   = commit_go;
        cmd.dir_up = req_up_r;
        wr_idx     = best_idx;
      end
      default: in_tready = 1'b0;
    endcase
  end

  always_comb begin
    k_nxt      = k_r;
    last_nxt   = last_r;
    req_up_nxt = req_up_r;
    if (state_r == ecd_pkg::S_IDLE) begin
      k_nxt      = '0;
      req_up_nxt = dest > this_floor_r;
      if (cars_r == '0) begin
        last_nxt = '0;
      end else if (32'(cars_r) > MAX_CARS) begin
        last_nxt = CW'(MAX_CARS - 1);
      end else begin
        last_nxt = CW'(cars_r - ecd_pkg::CARS_W'(1));
      end
    end else if (state_r == ecd_pkg::S_SCAN && !scan_last) begin
      k_nxt = k_r + CW'(1);
    end
    if (best_cost < 0) begin
      cost_sat = '0;
    end else if (best_cost > $signed(ecd_pkg::COST_W'(127))) begin
      cost_sat = ecd_pkg::OUT_COST_W'(127);
    end else begin
      cost_sat = best_cost[ecd_pkg::OUT_COST_W-1:0];
    end
    out_tdata_nxt = {5'b0, cost_sat, req_up_r, best_ext[2:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ecd_pkg::S_IDLE;
      k_r          <= '0;
      last_r       <= '0;
      req_up_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      last_r   <= last_nxt;
      req_up_r <= req_up_nxt;
      if (commit_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  ecd_car_table #(
    .MAX_CARS    (MAX_CARS),
    .MAX_WAITING (MAX_WAITING)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .wr_idx   (wr_idx),
    .wr_entry (wr_entry),
    .rd_idx   (k_r),
    .rd_up    (req_up_r),
    .rd_entry (rd_entry),
    .rd_wait  (rd_wait)
  );

  ecd_cost_unit #(
    .MAX_CARS    (MAX_CARS),
    .MAX_WAITING (MAX_WAITING)
  ) u_cost (
    .clk       (clk),
    .ctl       (ctl),
    .k         (k_r),
    .entry     (rd_entry),
    .wait_cnt  (rd_wait),
    .here      (this_floor_r),
    .top       (top_floor_r),
    .req_up    (req_up_r),
    .best_idx  (best_idx),
    .best_cost (best_cost)
  );

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == ecd_pkg::S_IDLE)
    else $error("input ready outside the idle state");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ecd_pkg::S_SCAN |-> k_r <= last_r)
    else $error("scan index beyond the last car in use");

  a_commit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ecd_pkg::S_COMMIT && out_tvalid_r && !out_tready)
      |=> state_r == ecd_pkg::S_COMMIT)
    else $error("request committed while the output register was full");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ecd_pkg::S_COMMIT))
    else $error("result appeared without a committed request");

endmodule

### tb/sv/tb_elevator_car_dispatch.sv
module tb_elevator_car_dispatch;

  typedef struct {
    ecd_pkg::opcode_t op;
    logic [2:0] idx;
    logic [6:0] floor;
    logic       busy;
    logic       going_up;
    logic       door_open;
    logic [7:0] room;
    logic       boarded_up;
    logic [6:0] dest;
  } car_cmd_t;

  typedef struct packed {
    logic [2:0] car;
    logic       up;
    logic [6:0] cost;
  } assignment_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_wr_en = 1'b0;
  logic [ecd_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [ecd_pkg::CFG_W-1:0]       cfg_wr_data = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [ecd_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [ecd_pkg::IN_TUSER_W-1:0]  in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [ecd_pkg::OUT_TDATA_W-1:0] out_tdata;

  elevator_car_dispatch uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the dispatcher: registers and car table.
  logic [6:0] serve_floor = 7'd1;
  logic [6:0] roof_floor  = 7'd16;
  logic [3:0] cars_used   = 4'd8;
  logic [6:0] car_pos[8];
  logic       car_busy_q[8];
  logic       car_up_q[8];
  logic       car_open_q[8];
  logic [7:0] car_room_q[8];
  logic [7:0] queued_up[8];
  logic [7:0] queued_down[8];

  car_cmd_t    pending_cmds[$];
  assignment_t expected_assignments[$];

  int  mismatches = 0;
  bit  calm = 1'b0;
  bit  in_moved = 1'b0;
  int  in_gap = 0;
  int  out_stall = 0;

  initial begin
    for (int k = 0; k < 8; k++) begin
      car_pos[k] = '0;
      car_busy_q[k] = 1'b0;
      car_up_q[k] = 1'b0;
      car_open_q[k] = 1'b0;
      car_room_q[k] = '0;
      queued_up[k] = '0;
      queued_down[k] = '0;
    end
  end

  function automatic void stage_cmd(car_cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int trip_cost(int k, bit req_up);
    int  here;
    int  pos;
    int  top;
    bit  approach_up;
    bit  same_dir;
    bit  at_here;
    bit  passing;
    here = serve_floor;
    pos = car_pos[k];
    top = roof_floor;
    approach_up = here > pos;
    same_dir = car_up_q[k] == req_up;
    at_here = (pos == here) && same_dir && car_open_q[k];
    passing = same_dir && (approach_up == car_up_q[k]);
    if (!car_busy_q[k] || at_here || passing) return pos > here ? pos - here : here - pos;
    if (car_up_q[k]) return 2 * top - here - pos;
    return here + pos - 2;
  endfunction

  function automatic void predict_dispatch(car_cmd_t c);
    int          n;
    int          best;
    int          best_cost;
    int          best_space;
    int          cost;
    int          space;
    bit          req_up;
    assignment_t a;
    case (c.op)
      ecd_pkg::OP_STATUS: begin
        car_pos[c.idx] = c.floor;
        car_busy_q[c.idx] = c.busy;
        car_up_q[c.idx] = c.going_up;
        car_open_q[c.idx] = c.door_open;
        car_room_q[c.idx] = c.room;
      end
      ecd_pkg::OP_BOARD: begin
        if (c.boarded_up) begin
          if (queued_up[c.idx] != 0) queued_up[c.idx]--;
        end else begin
          if (queued_down[c.idx] != 0) queued_down[c.idx]--;
        end
      end
      ecd_pkg::OP_REQUEST: begin
        req_up = c.dest > serve_floor;
        n = cars_used;
        if (n < 1) n = 1;
        if (n > 8) n = 8;
        best = 0;
        best_cost = 0;
        best_space = 0;
        for (int k = 0; k < n; k++) begin
          cost = trip_cost(k, req_up);
          space = int'(car_room_q[k]) - int'(req_up ? queued_up[k] : queued_down[k]);
          if (k == 0 || cost < best_cost || (cost == best_cost && space > best_space)) begin
            best = k;
            best_cost = cost;
            best_space = space;
          end
        end
        if (req_up) begin
          if (queued_up[best] != 8'd255) queued_up[best]++;
        end else begin
          if (queued_down[best] != 8'd255) queued_down[best]++;
        end
        if (best_cost < 0) best_cost = 0;
        if (best_cost > 127) best_cost = 127;
        a.car = best[2:0];
        a.up = req_up;
        a.cost = best_cost[6:0];
        expected_assignments.insert(expected_assignments.size(), a);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [ecd_pkg::IN_TDATA_W-1:0] pack_cmd(car_cmd_t c);
    logic [ecd_pkg::IN_TDATA_W-1:0] d;
    d = '0;
    d[2:0] = c.idx;
    d[9:3] = c.floor;
    d[10] = c.busy;
    d[11] = c.going_up;
    d[12] = c.door_open;
    d[20:13] = c.room;
    d[21] = c.boarded_up;
    d[28:22] = c.dest;
    return d;
  endfunction

  function automatic car_cmd_t make_cmd(ecd_pkg::opcode_t op, int idx, int floor, bit busy,
                                        bit going_up, bit door_open, int room,
                                        bit boarded_up, int dest);
    car_cmd_t c;
    c.op = op;
    c.idx = idx[2:0];
    c.floor = floor[6:0];
    c.busy = busy;
    c.going_up = going_up;
    c.door_open = door_open;
    c.room = room[7:0];
    c.boarded_up = boarded_up;
    c.dest = dest[6:0];
    return c;
  endfunction

  function automatic int any_floor();
    int hi;
    hi = (roof_floor >= 2 && roof_floor <= 64) ? roof_floor : 64;
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 127);
    return $urandom_range(1, hi);
  endfunction

  function automatic car_cmd_t random_cmd(bit crowd);
    car_cmd_t c;
    int       r;
    int       n;
    c = make_cmd(ecd_pkg::OP_NOP, $urandom_range(0, 7), $urandom_range(0, 127),
                 $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 127));
    n = (cars_used < 1) ? 1 : (cars_used > 8 ? 8 : cars_used);
    r = $urandom_range(0, 99);
    if (crowd) begin
      if (r < 94) begin
        c.op = ecd_pkg::OP_REQUEST;
        c.dest = ($urandom_range(0, 9) == 0) ? 7'(any_floor())
                                             : 7'($urandom_range(serve_floor + 1, 64));
      end else if (r < 97) begin
        c.op = ecd_pkg::OP_BOARD;
      end else begin
        c.op = ecd_pkg::OP_STATUS;
        c.floor = 7'(any_floor());
      end
    end else if (r < 30) begin
      c.op = ecd_pkg::OP_STATUS;
      c.floor = 7'(any_floor());
      if ($urandom_range(0, 3) != 0) c.idx = 3'($urandom_range(0, n - 1));
      if ($urandom_range(0, 4) == 0) c.floor = serve_floor;
    end else if (r < 75) begin
      c.op = ecd_pkg::OP_REQUEST;
      c.dest = 7'(any_floor());
    end else if (r < 95) begin
      c.op = ecd_pkg::OP_BOARD;
      if ($urandom_range(0, 3) != 0) c.idx = 3'($urandom_range(0, n - 1));
    end
    return c;
  endfunction

  task automatic write_reg(ecd_pkg::cfg_reg_t idx, int value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= value[ecd_pkg::CFG_W-1:0];
    @(posedge clk);
    case (idx)
      ecd_pkg::REG_THIS_FLOOR:  serve_floor = value[6:0];
      ecd_pkg::REG_TOP_FLOOR:   roof_floor = value[6:0];
      ecd_pkg::REG_CARS_IN_USE: cars_used = value[3:0];
      default: begin
      end
    endcase
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || expected_assignments.size() != 0 || in_tvalid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Input driver: holds an item until its transfer, then idles for a random gap.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_moved) begin
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= pack_cmd(pending_cmds[0]);
        in_tuser <= pending_cmds[0].op;
        in_gap <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    in_moved = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_dispatch(pending_cmds[0]);
      void'(pending_cmds.pop_front());
      in_moved = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 99) < 20) out_stall <= pick_gap();
    end
  end

  always @(posedge clk) begin
    assignment_t want;
    assignment_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.car = out_tdata[2:0];
      got.up = out_tdata[3];
      got.cost = out_tdata[10:4];
      if (expected_assignments.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result transfer: car %0d up %0b cost %0d",
                   got.car, got.up, got.cost);
        mismatches++;
      end else begin
        want = expected_assignments.pop_front();
        if (got.car !== want.car || got.up !== want.up || got.cost !== want.cost) begin
          if (mismatches < 10)
            $display("mismatch: expected car %0d up %0b cost %0d, got car %0d up %0b cost %0d",
                     want.car, want.up, want.cost, got.car, got.up, got.cost);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #12_000_000;
    $display("tb_elevator_car_dispatch NOT OK");
    $finish;
  end

  initial begin
    int this_set[10];
    int top_set[10];
    int cars_set[10];
    int count_set[10];
    this_set  = '{1, 8, 64, 1, 32, 20, 10, 0, 127, 5};
    top_set   = '{16, 16, 64, 2, 64, 40, 20, 127, 2, 12};
    cars_set  = '{8, 8, 8, 2, 0, 15, 1, 3, 9, 4};
    count_set = '{150, 150, 150, 150, 150, 150, 350, 100, 100, 100};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every car reports before any request, so no unreported floor is ever read.
    stage_cmd(make_cmd(ecd_pkg::OP_STATUS, 0, 1, 0, 0, 0, 255, 0, 0));
    stage_cmd(make_cmd(ecd_pkg::OP_STATUS, 1, 16, 1, 1, 0, 0, 1, 127));
    stage_cmd(make_cmd(ecd_pkg::OP_STATUS, 2, 1, 1, 1, 1, 10, 0, 0));
    stage_cmd(make_cmd(ecd_pkg::OP_STATUS, 3, 64, 1, 0, 0, 128, 1, 64));
    stage_cmd(make_cmd(ecd_pkg::OP_STATUS, 4, 127, 1, 0, 1, 1, 0, 1));
    stage_cmd(make_cmd(ecd_pkg::OP_STATUS, 5, 0, 1, 1, 0, 200, 1, 2));
    stage_cmd(make_cmd(ecd_pkg::OP_STATUS, 6, 8, 0, 1, 1, 77, 0, 3));
    stage_cmd(make_cmd(ecd_pkg::OP_STATUS, 7, 5, 1, 0, 0, 254, 1, 4));
    stage_cmd(make_cmd(ecd_pkg::OP_REQUEST, 7, 127, 1, 1, 1, 255, 1, 64));
    stage_cmd(make_cmd(ecd_pkg::OP_REQUEST, 0, 0, 0, 0, 0, 0, 0, 1));
    stage_cmd(make_cmd(ecd_pkg::OP_REQUEST, 3, 5, 0, 1, 0, 9, 0, 0));
    stage_cmd(make_cmd(ecd_pkg::OP_REQUEST, 5, 9, 1, 0, 1, 3, 1, 127));
    stage_cmd(make_cmd(ecd_pkg::OP_BOARD, 7, 0, 0, 0, 0, 0, 0, 0));
    stage_cmd(make_cmd(ecd_pkg::OP_BOARD, 0, 0, 0, 0, 0, 0, 1, 0));
    stage_cmd(make_cmd(ecd_pkg::OP_NOP, 7, 127, 1, 1, 1, 255, 1, 127));
    stage_cmd(make_cmd(ecd_pkg::OP_REQUEST, 2, 3, 1, 0, 1, 11, 0, 2));
    stage_cmd(make_cmd(ecd_pkg::OP_STATUS, 2, 1, 1, 0, 1, 50, 0, 0));
    stage_cmd(make_cmd(ecd_pkg::OP_REQUEST, 1, 0, 0, 1, 0, 0, 1, 1));
    stage_cmd(make_cmd(ecd_pkg::OP_BOARD, 2, 0, 0, 0, 0, 0, 1, 0));
    stage_cmd(make_cmd(ecd_pkg::OP_REQUEST, 4, 0, 0, 0, 0, 0, 0, 100));
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      write_reg(ecd_pkg::REG_THIS_FLOOR, this_set[p]);
      write_reg(ecd_pkg::REG_TOP_FLOOR, top_set[p]);
      write_reg(ecd_pkg::REG_CARS_IN_USE, cars_set[p]);
      @(negedge clk);
      cfg_wr_en <= 1'b0;
      @(posedge clk);
      calm = (p % 4) == 3;
      for (int i = 0; i < count_set[p]; i++) stage_cmd(random_cmd(p == 6));
      wait_idle();
    end

    repeat (30) @(posedge clk);
    if (mismatches == 0 && expected_assignments.size() == 0) begin
      $display("tb_elevator_car_dispatch OK");
    end else begin
      $display("tb_elevator_car_dispatch NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
sv/ecd_pkg.sv
sv/ecd_car_table.sv
sv/ecd_cost_unit.sv
sv/elevator_car_dispatch.sv
tb/sv/tb_elevator_car_dispatch.sv
